/* sv/tbt_pkg.sv */
`default_nettype none

package tbt_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned NORM_W     = 32;
  localparam int unsigned HOLD_W     = 36;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 36;

  localparam logic [NORM_W-1:0] NORMAL_TIMEOUT_RST    = 32'd120000000;
  localparam logic [HOLD_W-1:0] SERVICE_HOLD_TIME_RST = 36'd7200000000;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TIMEOUT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_HOLD_TIME = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CHECK = 2'd1,
    OP_PURGE = 2'd2
  } op_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } tbt_cmd_t;

endpackage

`default_nettype wire

/* sv/tbt_intf.sv */
`default_nettype none

interface tbt_req_if;
  logic                       valid;
  logic                       ready;
  logic [tbt_pkg::OP_W-1:0]   operation;
  logic [tbt_pkg::KEY_W-1:0]  resource_key;
  logic                       service_flag;
  logic [tbt_pkg::TIME_W-1:0] now_time;

  modport source (output valid, operation, resource_key, service_flag, now_time,
                  input ready);
  modport sink   (input valid, operation, resource_key, service_flag, now_time,
                  output ready);
endinterface

interface tbt_rsp_if;
  logic valid;
  logic ready;
  logic is_blocked;
  logic table_full;

  modport source (output valid, is_blocked, table_full, input ready);
  modport sink   (input valid, is_blocked, table_full, output ready);
endinterface

interface tbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbt_pkg::CFG_IDX_W-1:0]  index;
  logic [tbt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/tbt_ctrl.sv */
`default_nettype none

module tbt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output tbt_pkg::tbt_cmd_t      cmd_o
);
  import tbt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && req_valid_i;
    cmd_o.commit  = (state_q == S_EXEC) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/tbt_dp.sv */
`default_nettype none

module tbt_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tbt_pkg::tbt_cmd_t              cmd_i,
  input  wire logic [tbt_pkg::OP_W-1:0]       operation_i,
  input  wire logic [tbt_pkg::KEY_W-1:0]      resource_key_i,
  input  wire logic                           service_flag_i,
  input  wire logic [tbt_pkg::TIME_W-1:0]     now_time_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic [tbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tbt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                is_blocked_o,
  output logic                                table_full_o
);
  import tbt_pkg::*;

  logic [NORM_W-1:0] normal_timeout_q;
  logic [HOLD_W-1:0] service_hold_q;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic              svc_flag_q;
  logic [TIME_W-1:0] now_q;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] svc_q;
  logic [KEY_W-1:0]         ent_key_q [TABLE_ENTRIES];
  logic [TIME_W-1:0]        ent_exp_q [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx;
  logic                     free_any;
  logic [IDX_W-1:0]         free_idx;
  logic [HOLD_W-1:0]        hold;
  logic [TIME_W:0]          exp_sum;
  logic [TIME_W-1:0]        new_exp;
  logic                     expired;
  logic                     blocked_d, full_d;
  logic                     wr_en, wr_new;
  logic [IDX_W-1:0]         wr_idx;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (ent_key_q[i] == key_q);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign free_any = !(&valid_q);
  assign hold     = svc_flag_q ? service_hold_q : HOLD_W'(normal_timeout_q);
  assign exp_sum  = {1'b0, now_q} + (TIME_W + 1)'(hold);
  assign new_exp  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
  assign expired  = ent_exp_q[hit_idx] < now_q;

  always_comb begin
    valid_d   = valid_q;
    blocked_d = 1'b0;
    full_d    = 1'b0;
    wr_en     = 1'b0;
    wr_new    = 1'b0;
    wr_idx    = hit_idx;
    case (op_q)
      OP_ADD: begin
        if (hit_any) begin
          wr_en = svc_flag_q;
        end else if (free_any) begin
          wr_en            = 1'b1;
          wr_new           = 1'b1;
          wr_idx           = free_idx;
          valid_d[free_idx] = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
      OP_CHECK: begin
        if (hit_any) begin
          if (expired) begin
            valid_d[hit_idx] = 1'b0;
          end else begin
            blocked_d = 1'b1;
          end
        end
      end
      OP_PURGE: begin
        valid_d = valid_q & ~svc_q;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q          <= '0;
      normal_timeout_q <= NORMAL_TIMEOUT_RST;
      service_hold_q   <= SERVICE_HOLD_TIME_RST;
    end else begin
      if (cmd_i.commit) begin
        valid_q <= valid_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_NORMAL_TIMEOUT:    normal_timeout_q <= cfg_data_i[NORM_W-1:0];
          REG_SERVICE_HOLD_TIME: service_hold_q   <= cfg_data_i[HOLD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      key_q      <= resource_key_i;
      svc_flag_q <= service_flag_i;
      now_q      <= now_time_i;
    end
    if (cmd_i.commit) begin
      is_blocked_o <= blocked_d;
      table_full_o <= full_d;
      if (wr_en) begin
        ent_exp_q[wr_idx] <= new_exp;
        svc_q[wr_idx]     <= wr_new ? svc_flag_q : 1'b1;
        if (wr_new) begin
          ent_key_q[wr_idx] <= key_q;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/timed_blocklist_table_top.sv */
`default_nettype none

// Channel   Direction  Transfer when          Payload
// req_i     in         valid && ready         operation, resource_key, service_flag, now_time
// rsp_o     out        valid && ready         is_blocked, table_full
// cfg_i     in         valid (ready is high)  index, data
//
// Each operation first registers the request, then searches all table
// entries in parallel and updates the table.
// The update waits while the previous result is held in the output register and not yet taken.
// Reset clears all entry valid bits and loads the default hold times.
// A new request is taken while a finished result waits on the output.

module timed_blocklist_table_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tbt_req_if.sink   req_i,
  tbt_rsp_if.source rsp_o,
  tbt_cfg_if.sink   cfg_i
);
  import tbt_pkg::*;

  tbt_cmd_t cmd;
  logic     req_ready;
  logic     rsp_valid;

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign cfg_i.ready = 1'b1;

  tbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  tbt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (req_i.operation),
    .resource_key_i (req_i.resource_key),
    .service_flag_i (req_i.service_flag),
    .now_time_i     (req_i.now_time),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .is_blocked_o   (rsp_o.is_blocked),
    .table_full_o   (rsp_o.table_full)
  );

endmodule

`default_nettype wire
